// File: hdl/sphd_pkg.sv
// types, codes and helpers for the solenoid pull-and-hold driver
`timescale 1ns / 1ps

package sphd_pkg;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_ON   = 2'd1,
        CMD_OFF  = 2'd2,
        CMD_SET  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_PULL = 2'd1,
        MODE_HOLD = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_DUTY_CAP  = 3'd0,
        REG_PULL_TIME = 3'd1,
        REG_HOLD_DUTY = 3'd2,
        REG_MAX_ON    = 3'd3,
        REG_PWM_PER   = 3'd4
    } reg_idx_t;

    localparam int          CfgIdxW       = 3;
    localparam int          CfgDataW      = 32;
    localparam int          ProdW         = 23;
    localparam int          RecipW        = 24;
    localparam int          RecipShift    = 30;
    localparam int          ScaledW       = ProdW + RecipW;
    localparam logic [23:0] RECIP_100     = 24'd10737419;
    localparam logic [7:0]  FULL_DUTY     = 8'd100;
    localparam logic [6:0]  DUTY_CAP_RST  = 7'd100;
    localparam logic [15:0] PULL_TIME_RST = 16'd200;
    localparam logic [6:0]  HOLD_DUTY_RST = 7'd30;
    localparam logic [31:0] MAX_ON_RST    = 32'd0;
    localparam logic [15:0] PWM_PER_RST   = 16'd1000;

    // requested duty limited by the cap
    function automatic logic [6:0] cap_duty(input logic [7:0] pct, input logic [6:0] cap);
        logic [6:0] res;
        if (pct > {1'b0, cap})
        begin
            res = cap;
        end
        else
        begin
            res = pct[6:0];
        end
        return res;
    endfunction

endpackage

// File: hdl/solenoid_pull_hold_driver_core.sv
// solenoid pull-and-hold pwm driver: command decode, state update, compare scaling
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, cmd, duty_pct, now_ms | to block
//  out     | out_valid, out_ready, mode, duty_out,     | from block
//          | compare_value, on_time_ms, timed_out      |
//  cfg     | cfg_we, cfg_index, cfg_data               | to block
//
//  one item per cycle sustained while out_ready stays high; each item is registered at every stage below
//  stages: input register, state update and duty-period multiply, divide by 100 and saturate
//  the multiply into the reciprocal scaling sets the stage split
//  reset clears state, config to defaults and all valid flags
//  a stalled output holds every stage that has nowhere to go; ready follows from that
`timescale 1ns / 1ps

module solenoid_pull_hold_driver_core
    import sphd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [7:0]          duty_pct,
    input  logic [31:0]         now_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          mode,
    output logic [6:0]          duty_out,
    output logic [15:0]         compare_value,
    output logic [31:0]         on_time_ms,
    output logic                timed_out
);

    // configuration
    logic [6:0]  duty_cap_reg;
    logic [15:0] pull_time_reg;
    logic [6:0]  hold_duty_reg;
    logic [31:0] max_on_reg;
    logic [15:0] pwm_period_reg;

    // driver state
    mode_t       mode_reg, mode_next;
    logic [6:0]  duty_reg, duty_next;
    logic [31:0] on_start_reg, on_start_next;
    logic        anchored_reg, anchored_next;
    logic        manual_reg, manual_next;

    // pipeline
    logic        in_valid_reg;
    cmd_t        in_cmd_reg;
    logic [7:0]  in_duty_reg;
    logic [31:0] in_now_reg;

    logic             a_valid_reg;
    logic [ProdW-1:0] a_prod_reg, a_prod_next;
    logic [31:0]      a_on_time_reg, a_on_time_next;
    logic             a_timed_reg, a_timed_next;

    logic        out_valid_reg;
    mode_t       out_mode_reg;
    logic [6:0]  out_duty_reg;
    logic [15:0] out_cmp_reg, out_cmp_next;
    logic [31:0] out_on_time_reg;
    logic        out_timed_reg;

    logic in_take, a_load, b_load, out_fire;

    logic [31:0]        start_base;
    logic [31:0]        elapsed;
    logic [ScaledW-1:0] scaled;
    logic [16:0]        quot;

    assign out_fire = out_valid_reg & out_ready;
    assign b_load   = a_valid_reg & (~out_valid_reg | out_ready);
    assign a_load   = in_valid_reg & (~a_valid_reg | b_load);
    assign in_ready = ~in_valid_reg | a_load;
    assign in_take  = in_valid & in_ready;

    // on-time of the item in the input register; zero when not yet anchored
    assign start_base = anchored_reg ? on_start_reg : in_now_reg;
    assign elapsed    = in_now_reg - start_base;

    always_comb
    begin
        mode_next     = mode_reg;
        duty_next     = duty_reg;
        on_start_next = on_start_reg;
        anchored_next = anchored_reg;
        manual_next   = manual_reg;
        a_timed_next  = 1'b0;

        unique case (in_cmd_reg)
            CMD_TICK:
            begin
                if (mode_reg == MODE_OFF)
                begin
                    anchored_next = 1'b0;
                    on_start_next = '0;
                end
                else
                begin
                    anchored_next = 1'b1;
                    on_start_next = start_base;
                    if (mode_reg == MODE_PULL && !manual_reg
                        && elapsed >= {16'd0, pull_time_reg})
                    begin
                        mode_next = MODE_HOLD;
                        duty_next = cap_duty({1'b0, hold_duty_reg}, duty_cap_reg);
                    end
                    if (max_on_reg != '0 && elapsed >= max_on_reg)
                    begin
                        mode_next     = MODE_OFF;
                        manual_next   = 1'b0;
                        anchored_next = 1'b0;
                        on_start_next = '0;
                        duty_next     = '0;
                        a_timed_next  = 1'b1;
                    end
                end
            end
            CMD_ON:
            begin
                mode_next     = MODE_PULL;
                manual_next   = 1'b0;
                anchored_next = 1'b0;
                on_start_next = '0;
                duty_next     = cap_duty(FULL_DUTY, duty_cap_reg);
            end
            CMD_OFF:
            begin
                mode_next     = MODE_OFF;
                manual_next   = 1'b0;
                anchored_next = 1'b0;
                on_start_next = '0;
                duty_next     = '0;
            end
            CMD_SET:
            begin
                if (in_duty_reg == '0)
                begin
                    mode_next     = MODE_OFF;
                    manual_next   = 1'b0;
                    anchored_next = 1'b0;
                    on_start_next = '0;
                    duty_next     = '0;
                end
                else
                begin
                    manual_next = 1'b1;
                    mode_next   = MODE_HOLD;
                    duty_next   = cap_duty(in_duty_reg, duty_cap_reg);
                end
            end
        endcase

        if (mode_next != MODE_OFF && anchored_next)
        begin
            a_on_time_next = in_now_reg - on_start_next;
        end
        else
        begin
            a_on_time_next = '0;
        end

        a_prod_next = {{(ProdW-7){1'b0}}, duty_next} * {{(ProdW-16){1'b0}}, pwm_period_reg};
    end

    // divide by 100 through the reciprocal, then saturate to the timer width
    assign scaled = {{RecipW{1'b0}}, a_prod_reg} * {{ProdW{1'b0}}, RECIP_100};
    assign quot   = scaled[RecipShift +: 17];

    always_comb
    begin
        if (quot[16])
        begin
            out_cmp_next = 16'hFFFF;
        end
        else
        begin
            out_cmp_next = quot[15:0];
        end
    end

    // control, state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_cap_reg   <= DUTY_CAP_RST;
            pull_time_reg  <= PULL_TIME_RST;
            hold_duty_reg  <= HOLD_DUTY_RST;
            max_on_reg     <= MAX_ON_RST;
            pwm_period_reg <= PWM_PER_RST;
            mode_reg       <= MODE_OFF;
            duty_reg       <= '0;
            on_start_reg   <= '0;
            anchored_reg   <= 1'b0;
            manual_reg     <= 1'b0;
            in_valid_reg   <= 1'b0;
            a_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DUTY_CAP:  duty_cap_reg   <= cfg_data[6:0];
                    REG_PULL_TIME: pull_time_reg  <= cfg_data[15:0];
                    REG_HOLD_DUTY: hold_duty_reg  <= cfg_data[6:0];
                    REG_MAX_ON:    max_on_reg     <= cfg_data[31:0];
                    REG_PWM_PER:   pwm_period_reg <= cfg_data[15:0];
                    default:       ;
                endcase
            end

            if (a_load)
            begin
                mode_reg     <= mode_next;
                duty_reg     <= duty_next;
                on_start_reg <= on_start_next;
                anchored_reg <= anchored_next;
                manual_reg   <= manual_next;
            end

            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (a_load)
            begin
                in_valid_reg <= 1'b0;
            end

            if (a_load)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (b_load)
            begin
                a_valid_reg <= 1'b0;
            end

            if (b_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= cmd_t'(cmd);
            in_duty_reg <= duty_pct;
            in_now_reg  <= now_ms;
        end
        if (a_load)
        begin
            a_prod_reg    <= a_prod_next;
            a_on_time_reg <= a_on_time_next;
            a_timed_reg   <= a_timed_next;
        end
        if (b_load)
        begin
            out_mode_reg    <= mode_reg;
            out_duty_reg    <= duty_reg;
            out_cmp_reg     <= out_cmp_next;
            out_on_time_reg <= a_on_time_reg;
            out_timed_reg   <= a_timed_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mode          = out_mode_reg;
    assign duty_out      = out_duty_reg;
    assign compare_value = out_cmp_reg;
    assign on_time_ms    = out_on_time_reg;
    assign timed_out     = out_timed_reg;

    // a timeout always leaves the coil off with no duty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> mode == MODE_OFF && duty_out == '0)
    else $error("timeout result not switched off");

    // off means no duty and no on-time
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode == MODE_OFF |-> duty_out == '0 && on_time_ms == '0)
    else $error("off result carries duty or on-time");

    // zero duty scales to a zero compare value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && duty_out == '0 |-> compare_value == '0)
    else $error("compare value nonzero at zero duty");

    // input stage only blocks while it holds an item that cannot move on
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && a_valid_reg && out_valid_reg && !out_ready)
    else $error("input stalled without a full pipeline");

endmodule
